@@ src/sst_pkg.sv @@
package sst_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int ISQRT_STEPS  = 32;
   localparam int XY_W         = 36;
   localparam int Z_W          = 33;

   // latency of each unit, input register to output register
   localparam int SINCOS_LAT = CORDIC_STEPS + 2;
   localparam int ISQRT_LAT  = ISQRT_STEPS + 1;
   localparam int VECTOR_LAT = CORDIC_STEPS + 1;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = 36'sd652032874;
   localparam logic [30:0]  HALF_PI_Q30      = 31'd1686629713;
   localparam logic signed [31:0] TWO_OVER_PI_Q30 = 32'sd683565276;
   localparam logic signed [33:0] COS_ZENITH_Q30  = -34'sd15616391;
   localparam logic signed [31:0] RAD_TO_MIN_Q16  = 32'sd15019745;
   localparam logic [24:0]  TURNS_PER_96TH_Q8 = 25'd31330473;
   localparam logic signed [31:0] NOON_MIN_Q16    = 32'sd47185920;
   localparam logic signed [23:0] LAT_LIMIT       = 24'sd5898240;
   localparam int DAY_SECONDS = 86400;

   localparam logic signed [31:0] EQ_BIAS  = 32'sd1126;
   localparam logic signed [31:0] DEC_BIAS = 32'sd7428146;
   localparam logic signed [31:0] EQ_C1  = 32'sd28056;
   localparam logic signed [31:0] EQ_S1  = -32'sd481782;
   localparam logic signed [31:0] EQ_C2  = -32'sd219511;
   localparam logic signed [31:0] EQ_S2  = -32'sd613533;
   localparam logic signed [31:0] DEC_C1 = -32'sd429402240;
   localparam logic signed [31:0] DEC_S1 = 32'sd75437879;
   localparam logic signed [31:0] DEC_C2 = -32'sd7256347;
   localparam logic signed [31:0] DEC_S2 = 32'sd973884;
   localparam logic signed [31:0] DEC_C3 = -32'sd2895882;
   localparam logic signed [31:0] DEC_S3 = 32'sd1589138;

   typedef enum logic [1:0] {
      CSR_LATITUDE  = 2'd0,
      CSR_LONGITUDE = 2'd1,
      CSR_ZONE      = 2'd2
   } csr_index_type;

   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      33'sh3243F6A8, 33'sh1DAC6705, 33'sh0FADBAFC, 33'sh07F56EA6, 33'sh03FEAB76,
      33'sh01FFD55B, 33'sh00FFFAAA, 33'sh007FFF55, 33'sh003FFFEA, 33'sh001FFFFD,
      33'sh000FFFFF, 33'sh0007FFFF, 33'sh0003FFFF, 33'sh0001FFFF, 33'sh0000FFFF,
      33'sh00007FFF, 33'sh00003FFF, 33'sh00001FFF, 33'sh00000FFF, 33'sh000007FF,
      33'sh000003FF, 33'sh000001FF, 33'sh000000FF, 33'sh0000007F, 33'sh0000003F,
      33'sh0000001F, 33'sh0000000F, 33'sh00000008, 33'sh00000004, 33'sh00000002
   };

   // round half up, then drop 30 fraction bits
   function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
      return (v + 64'sd536870912) >>> 30;
   endfunction

endpackage

@@ src/sst_sincos.sv @@
module sst_sincos (
   input  logic               clock,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   localparam int Steps = sst_pkg::CORDIC_STEPS;
   localparam int XyW   = sst_pkg::XY_W;
   localparam int ZW    = sst_pkg::Z_W;

   logic [60:0]              zprod;
   logic [1:0]               quad_ff [0:Steps];
   logic signed [XyW-1:0]    x_ff    [0:Steps];
   logic signed [XyW-1:0]    y_ff    [0:Steps];
   logic signed [ZW-1:0]     z_ff    [0:Steps];
   logic signed [31:0]       cos_ff, sin_ff;

   assign zprod = 61'(phase[29:0]) * 61'(sst_pkg::HALF_PI_Q30) + 61'(30'h2000_0000);

   always_ff @(posedge clock) begin
      quad_ff[0] <= phase[31:30];
      x_ff[0]    <= sst_pkg::CORDIC_GAIN_INV;
      y_ff[0]    <= '0;
      z_ff[0]    <= ZW'(signed'({2'b00, zprod[60:30]}));
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_ff @(posedge clock) begin
         quad_ff[i+1] <= quad_ff[i];
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - sst_pkg::ATAN_TAB[i];
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + sst_pkg::ATAN_TAB[i];
         end
      end
   end

   // fold the first-quadrant result back to the full circle
   always_ff @(posedge clock) begin
      case (quad_ff[Steps])
         2'd0: begin
            cos_ff <= x_ff[Steps][31:0];
            sin_ff <= y_ff[Steps][31:0];
         end
         2'd1: begin
            cos_ff <= -y_ff[Steps][31:0];
            sin_ff <= x_ff[Steps][31:0];
         end
         2'd2: begin
            cos_ff <= -x_ff[Steps][31:0];
            sin_ff <= -y_ff[Steps][31:0];
         end
         default: begin
            cos_ff <= y_ff[Steps][31:0];
            sin_ff <= -x_ff[Steps][31:0];
         end
      endcase
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ src/sst_isqrt.sv @@
module sst_isqrt (
   input  logic        clock,
   input  logic [63:0] square_a,
   input  logic [63:0] square_b,
   output logic [31:0] root
);

   localparam int Steps = sst_pkg::ISQRT_STEPS;

   logic [63:0] v_ff [0:Steps];
   logic [63:0] r_ff [0:Steps];

   always_ff @(posedge clock) begin
      v_ff[0] <= square_a - square_b;
      r_ff[0] <= '0;
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      localparam logic [63:0] Bit = 64'd1 << (2 * (Steps - 1 - i));
      logic [63:0] trial;
      assign trial = r_ff[i] + Bit;
      always_ff @(posedge clock) begin
         if (v_ff[i] >= trial) begin
            v_ff[i+1] <= v_ff[i] - trial;
            r_ff[i+1] <= (r_ff[i] >> 1) + Bit;
         end else begin
            v_ff[i+1] <= v_ff[i];
            r_ff[i+1] <= r_ff[i] >> 1;
         end
      end
   end

   assign root = r_ff[Steps][31:0];

endmodule

@@ src/sst_vector.sv @@
module sst_vector (
   input  logic                           clock,
   input  logic [31:0]                    x_in,
   input  logic [31:0]                    y_in,
   output logic signed [sst_pkg::Z_W-1:0] angle
);

   localparam int Steps = sst_pkg::CORDIC_STEPS;
   localparam int XyW   = sst_pkg::XY_W;
   localparam int ZW    = sst_pkg::Z_W;

   logic signed [XyW-1:0] x_ff [0:Steps];
   logic signed [XyW-1:0] y_ff [0:Steps];
   logic signed [ZW-1:0]  z_ff [0:Steps];

   always_ff @(posedge clock) begin
      x_ff[0] <= XyW'(signed'({1'b0, x_in}));
      y_ff[0] <= XyW'(signed'({1'b0, y_in}));
      z_ff[0] <= '0;
   end

   // rotate toward the x axis, sum the angles taken
   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (!y_ff[i][XyW-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + sst_pkg::ATAN_TAB[i];
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - sst_pkg::ATAN_TAB[i];
         end
      end
   end

   assign angle = z_ff[Steps];

endmodule

@@ src/sunrise_sunset_time_top.sv @@
// Throughput: one item per cycle; busy is low outside reset, results never stall.
// Depth is set by two sin/cos CORDIC passes, the 32-step square root and the
// arccosine CORDIC, one iteration per stage.
// Reset clears the configuration registers and all valid bits; no clearing pass.
module sunrise_sunset_time_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_day_of_month,
   input  logic [3:0]  req_month_number,
   input  logic        req_want_sunrise,
   output logic        rsp_valid,
   output logic [16:0] rsp_event_seconds,
   output logic        rsp_no_event,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_write_data
);

   localparam int S_PH  = 3;
   localparam int S_LAT = 5;
   localparam int S_CS1 = S_PH + sst_pkg::SINCOS_LAT;
   localparam int S_PRD = S_CS1 + 1;
   localparam int S_SUM = S_PRD + 1;
   localparam int S_DPH = S_SUM + 1;
   localparam int S_CS2 = S_DPH + sst_pkg::SINCOS_LAT;
   localparam int S_PQ  = S_CS2 + 1;
   localparam int S_ND  = S_PQ + 1;
   localparam int S_AN  = S_ND + 1;
   localparam int S_SQ  = S_AN + 1;
   localparam int S_RT  = S_SQ + sst_pkg::ISQRT_LAT;
   localparam int S_ANG = S_RT + sst_pkg::VECTOR_LAT;
   localparam int S_HA  = S_ANG + 1;
   localparam int S_TOT = S_HA + 1;
   localparam int S_SEC = S_TOT + 1;
   localparam int S_OUT = S_SEC + 1;

   // configuration
   logic signed [23:0] lat_ff;
   logic signed [24:0] lon_ff;
   logic signed [16:0] zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff  <= '0;
         lon_ff  <= '0;
         zone_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sst_pkg::CSR_LATITUDE:  lat_ff  <= csr_write_data[23:0];
            sst_pkg::CSR_LONGITUDE: lon_ff  <= csr_write_data;
            sst_pkg::CSR_ZONE:      zone_ff <= csr_write_data[16:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // valid bits
   logic [S_OUT:1] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[S_OUT-1:1], start & ~busy};
   end

   // stage 1: day index in 96ths of a day, latitude offset to unsigned
   logic [3:0]         mm1;
   logic [4:0]         dm1;
   logic signed [23:0] lat_sat;
   logic [15:0]        d96_ff;
   logic [23:0]        lofs1_ff, lofs2_ff;

   assign mm1 = req_month_number - 4'd1;
   assign dm1 = req_day_of_month - 5'd1;

   always_comb begin
      if (lat_ff > sst_pkg::LAT_LIMIT)       lat_sat = sst_pkg::LAT_LIMIT;
      else if (lat_ff < -sst_pkg::LAT_LIMIT) lat_sat = -sst_pkg::LAT_LIMIT;
      else                                   lat_sat = lat_ff;
   end

   // stage 2 and on: phases, latitude phase as floor((L*8192+22)/45) - 2^30, L the offset latitude
   logic [40:0] ph_prod;
   logic [48:0] a_prod;
   logic [18:0] a_ff, a3_ff, a4_ff;
   logic [5:0]  b_ff;
   logic [18:0] t_num;
   logic [38:0] t_prod;
   logic [12:0] t_ff;
   logic [31:0] ph1_ff, ph1d_ff, ph2_ff, ph3_ff;
   logic [31:0] latph_ff [S_LAT:S_DPH];
   logic        rise_ff  [1:S_HA];

   assign ph_prod = 41'(d96_ff) * 41'(sst_pkg::TURNS_PER_96TH_Q8);
   assign a_prod  = 49'(lofs1_ff) * 49'd23860930;
   assign t_num   = {b_ff, 13'd0} + 19'd22;
   assign t_prod  = 39'(t_num) * 39'd745655;

   always_ff @(posedge clock) begin
      d96_ff   <= 16'(mm1) * 16'd2922 + 16'(dm1) * 16'd96
                  + (req_want_sunrise ? 16'd72 : 16'd24);
      lofs1_ff <= 24'(lat_sat + 24'sd5898240);
      ph1_ff   <= ph_prod[39:8];
      a_ff     <= a_prod[48:30];
      lofs2_ff <= lofs1_ff;
      ph1d_ff  <= ph1_ff;
      ph2_ff   <= {ph1_ff[30:0], 1'b0};
      ph3_ff   <= ph1_ff + {ph1_ff[30:0], 1'b0};
      b_ff     <= 6'(lofs2_ff - 24'(a_ff) * 24'd45);
      a3_ff    <= a_ff;
      t_ff     <= t_prod[37:25];
      a4_ff    <= a3_ff;
      latph_ff[S_LAT] <= {a4_ff, 13'd0} + 32'(t_ff) - 32'h4000_0000;
      for (int n = S_LAT + 1; n <= S_DPH; n++) latph_ff[n] <= latph_ff[n-1];
      rise_ff[1] <= req_want_sunrise;
      for (int n = 2; n <= S_HA; n++) rise_ff[n] <= rise_ff[n-1];
   end

   // first pass: harmonics of the fractional year
   logic signed [31:0] c1, s1, c2, s2, c3, s3;

   sst_sincos u_cs1 (.clock(clock), .phase(ph1d_ff), .cos_out(c1), .sin_out(s1));
   sst_sincos u_cs2 (.clock(clock), .phase(ph2_ff),  .cos_out(c2), .sin_out(s2));
   sst_sincos u_cs3 (.clock(clock), .phase(ph3_ff),  .cos_out(c3), .sin_out(s3));

   logic signed [63:0] pe_ff [4];
   logic signed [63:0] pd_ff [6];
   logic signed [63:0] eq_sum, dec_sum, eq_r, dec_r, dph_prod, dph_r;
   logic signed [31:0] dec_ff;
   logic [31:0]        dph_ff;
   logic signed [23:0] eq_ff [S_SUM:S_HA];

   assign eq_sum  = pe_ff[0] + pe_ff[1] + pe_ff[2] + pe_ff[3];
   assign dec_sum = pd_ff[0] + pd_ff[1] + pd_ff[2] + pd_ff[3] + pd_ff[4] + pd_ff[5];
   assign eq_r    = sst_pkg::rnd30(eq_sum) + 64'(sst_pkg::EQ_BIAS);
   assign dec_r   = sst_pkg::rnd30(dec_sum) + 64'(sst_pkg::DEC_BIAS);
   assign dph_prod = 64'(dec_ff) * 64'(sst_pkg::TWO_OVER_PI_Q30);
   assign dph_r    = sst_pkg::rnd30(dph_prod);

   always_ff @(posedge clock) begin
      pe_ff[0] <= 64'(c1) * 64'(sst_pkg::EQ_C1);
      pe_ff[1] <= 64'(s1) * 64'(sst_pkg::EQ_S1);
      pe_ff[2] <= 64'(c2) * 64'(sst_pkg::EQ_C2);
      pe_ff[3] <= 64'(s2) * 64'(sst_pkg::EQ_S2);
      pd_ff[0] <= 64'(c1) * 64'(sst_pkg::DEC_C1);
      pd_ff[1] <= 64'(s1) * 64'(sst_pkg::DEC_S1);
      pd_ff[2] <= 64'(c2) * 64'(sst_pkg::DEC_C2);
      pd_ff[3] <= 64'(s2) * 64'(sst_pkg::DEC_S2);
      pd_ff[4] <= 64'(c3) * 64'(sst_pkg::DEC_C3);
      pd_ff[5] <= 64'(s3) * 64'(sst_pkg::DEC_S3);
      eq_ff[S_SUM] <= eq_r[23:0];
      for (int n = S_SUM + 1; n <= S_HA; n++) eq_ff[n] <= eq_ff[n-1];
      dec_ff <= dec_r[31:0];
      dph_ff <= dph_r[31:0];
   end

   // second pass: declination and latitude
   logic signed [31:0] cd, sd, cl, sl;

   sst_sincos u_csd (.clock(clock), .phase(dph_ff), .cos_out(cd), .sin_out(sd));
   sst_sincos u_csl (.clock(clock), .phase(latph_ff[S_DPH]), .cos_out(cl), .sin_out(sl));

   logic signed [63:0] pss_ff, pcc_ff, pss_r, pcc_r;
   logic signed [33:0] num_ff, den_ff, an_abs;
   logic [31:0]        den3_ff;
   logic [31:0]        an_ff [S_AN:S_RT];
   logic [1:0]         nf_ff [S_AN:S_SEC];   // {num negative, no event}
   logic [63:0]        dd_ff, nn_ff;

   assign pss_r  = sst_pkg::rnd30(pss_ff);
   assign pcc_r  = sst_pkg::rnd30(pcc_ff);
   assign an_abs = num_ff[33] ? -num_ff : num_ff;

   always_ff @(posedge clock) begin
      pss_ff  <= 64'(sl) * 64'(sd);
      pcc_ff  <= 64'(cl) * 64'(cd);
      num_ff  <= sst_pkg::COS_ZENITH_Q30 - pss_r[33:0];
      den_ff  <= pcc_r[33:0];
      an_ff[S_AN] <= an_abs[31:0];
      for (int n = S_AN + 1; n <= S_RT; n++) an_ff[n] <= an_ff[n-1];
      nf_ff[S_AN] <= {num_ff[33], (den_ff <= 34'sd0) || (an_abs > den_ff)};
      for (int n = S_AN + 1; n <= S_SEC; n++) nf_ff[n] <= nf_ff[n-1];
      den3_ff <= den_ff[31:0];
      dd_ff   <= 64'(den3_ff) * 64'(den3_ff);
      nn_ff   <= 64'(an_ff[S_AN]) * 64'(an_ff[S_AN]);
   end

   logic [31:0]                    root;
   logic signed [sst_pkg::Z_W-1:0] ang;

   sst_isqrt  u_sqrt (.clock(clock), .square_a(dd_ff), .square_b(nn_ff), .root(root));
   sst_vector u_acos (.clock(clock), .x_in(an_ff[S_RT]), .y_in(root), .angle(ang));

   // hour angle in minutes, event time, wrap into the day
   logic signed [63:0] ha_prod, ha_r;
   logic signed [31:0] ha_ff, ha2, tot_ff, tot_adj, whole, secs;
   logic [19:0]        r_ff, r_rem;
   logic [16:0]        ev_ff;
   logic               ne_ff;

   assign ha_prod = 64'(ang) * 64'(sst_pkg::RAD_TO_MIN_Q16);
   assign ha_r    = sst_pkg::rnd30(ha_prod);
   assign ha2     = nf_ff[S_HA][1] ? sst_pkg::NOON_MIN_Q16 - ha_ff : ha_ff;
   assign tot_adj = tot_ff + (tot_ff[31] ? 32'sd65535 : 32'sd0);
   assign whole   = tot_adj >>> 16;
   assign secs    = whole * 32'sd60 + 32'(zone_ff) + 32'(2 * sst_pkg::DAY_SECONDS);

   always_comb begin
      if (r_ff >= 20'(4 * sst_pkg::DAY_SECONDS))
         r_rem = r_ff - 20'(4 * sst_pkg::DAY_SECONDS);
      else if (r_ff >= 20'(3 * sst_pkg::DAY_SECONDS))
         r_rem = r_ff - 20'(3 * sst_pkg::DAY_SECONDS);
      else if (r_ff >= 20'(2 * sst_pkg::DAY_SECONDS))
         r_rem = r_ff - 20'(2 * sst_pkg::DAY_SECONDS);
      else if (r_ff >= 20'(sst_pkg::DAY_SECONDS))
         r_rem = r_ff - 20'(sst_pkg::DAY_SECONDS);
      else
         r_rem = r_ff;
   end

   always_ff @(posedge clock) begin
      ha_ff  <= ha_r[31:0];
      tot_ff <= sst_pkg::NOON_MIN_Q16 - (32'(lon_ff) <<< 2) - 32'(eq_ff[S_HA])
                + (rise_ff[S_HA] ? -ha2 : ha2);
      r_ff   <= secs[19:0];
      ev_ff  <= nf_ff[S_SEC][0] ? 17'd0 : r_rem[16:0];
      ne_ff  <= nf_ff[S_SEC][0];
   end

   assign rsp_valid         = vld_ff[S_OUT];
   assign rsp_event_seconds = ev_ff;
   assign rsp_no_event      = ne_ff;

endmodule

@@ tb/sv/sunrise_sunset_time_top_test.sv @@
module sunrise_sunset_time_top_test;

   localparam logic [1:0] CSR_SPARE = 2'd3;   // past the register list, writes drop
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      bit [16:0] secs;
      bit        none;
   } sun_event_type;

   class sun_event_board_type;
      sun_event_type      awaited[$];
      logic signed [23:0] lat_q16;
      logic signed [24:0] lon_q16;
      logic signed [16:0] zone_s;
      int                 errors;
      longint             atan_q30[30];

      function new();
         atan_q30 = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
            64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
         lat_q16 = '0;
         lon_q16 = '0;
         zone_s  = '0;
         errors  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [24:0] data);
         case (idx)
            sst_pkg::CSR_LATITUDE:  lat_q16 = data[23:0];
            sst_pkg::CSR_LONGITUDE: lon_q16 = data;
            sst_pkg::CSR_ZONE:      zone_s  = data[16:0];
            default: ;
         endcase
      endfunction

      function longint round_q30(longint v);
         return (v + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function void turn_sincos(bit [31:0] t, output longint co, output longint si);
         longint unsigned rem;
         longint x, y, z, dx, dy;
         rem = t[29:0];
         z = longint'((rem * 64'd1686629713 + 64'd536870912) >> 30);
         x = 652032874;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_q30[i];
            end else begin
               x += dx; y -= dy; z += atan_q30[i];
            end
         end
         case (t[31:30])
            2'd0: begin co = x;  si = y;  end
            2'd1: begin co = -y; si = x;  end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
         endcase
      endfunction

      function longint vector_angle(longint x, longint y);
         longint z, dx, dy;
         z = 0;
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += atan_q30[i];
            end else begin
               x -= dx; y += dy; z -= atan_q30[i];
            end
         end
         return z;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function sun_event_type solar_event(bit [4:0] day, bit [3:0] month, bit rise);
         sun_event_type ev;
         bit [4:0] dm1;
         bit [3:0] mm1;
         longint unsigned d96, dn, nn;
         bit [31:0] ph1, ph2, ph3;
         longint c1, s1, c2, s2, c3, s3, cl, sl, cd, sd;
         longint eq_min, decl, lat, arg, q, num, den, an, ang, ha, total, whole, secs;
         dm1 = day - 5'd1;
         mm1 = month - 4'd1;
         d96 = mm1 * 64'd2922 + dm1 * 64'd96 + (rise ? 64'd72 : 64'd24);
         ph1 = 32'((d96 * 64'd31330473) >> 8);
         ph2 = ph1 * 32'd2;
         ph3 = ph1 * 32'd3;
         turn_sincos(ph1, c1, s1);
         turn_sincos(ph2, c2, s2);
         turn_sincos(ph3, c3, s3);
         eq_min = 1126 + round_q30(28056 * c1 - 481782 * s1 - 219511 * c2 - 613533 * s2);
         decl = 7428146 + round_q30(-429402240 * c1 + 75437879 * s1 - 7256347 * c2
                                    + 973884 * s2 - 2895882 * c3 + 1589138 * s3);
         lat = lat_q16;
         if (lat > 5898240) lat = 5898240;
         if (lat < -5898240) lat = -5898240;
         arg = lat * 131072 + 360;
         q = arg / 720;
         if (arg % 720 != 0 && arg < 0) q--;
         turn_sincos(q[31:0], cl, sl);
         q = round_q30(decl * 683565276);
         turn_sincos(q[31:0], cd, sd);
         num = -15616391 - round_q30(sl * sd);
         den = round_q30(cl * cd);
         an = num < 0 ? -num : num;
         if (den <= 0 || an > den) begin
            ev.secs = '0;
            ev.none = 1'b1;
            return ev;
         end
         dn = den;
         nn = an;
         ang = vector_angle(an, longint'(int_sqrt(dn * dn - nn * nn)));
         ha = round_q30(ang * 15019745);
         if (num < 0) ha = 47185920 - ha;
         total = 47185920 - 4 * longint'(lon_q16) - eq_min;
         total += rise ? -ha : ha;
         whole = total / 65536;
         secs = whole * 60 + longint'(zone_s);
         secs %= 86400;
         if (secs < 0) secs += 86400;
         ev.secs = secs[16:0];
         ev.none = 1'b0;
         return ev;
      endfunction

      function void note_query(bit [4:0] day, bit [3:0] month, bit rise);
         awaited.push_back(solar_event(day, month, rise));
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_event(bit [16:0] secs, bit none);
         sun_event_type ev;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected beat secs=%0d no_event=%0b", secs, none));
            return;
         end
         ev = awaited.pop_front();
         if (secs != ev.secs)
            report($sformatf("event_seconds %0d, expected %0d", secs, ev.secs));
         if (none != ev.none)
            report($sformatf("no_event %0b, expected %0b", none, ev.none));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [4:0]  req_day_of_month = '0;
   logic [3:0]  req_month_number = '0;
   logic        req_want_sunrise = 1'b0;
   logic        rsp_valid;
   logic [16:0] rsp_event_seconds;
   logic        rsp_no_event;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = sst_pkg::CSR_LATITUDE;
   logic [24:0] csr_write_data = '0;

   sun_event_board_type board = new();

   sunrise_sunset_time_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_event(rsp_event_seconds, rsp_no_event);

   // drop the enable after each write
   task write_reg(logic [1:0] idx, logic [24:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_reg(idx, data);
      @(posedge clock);
   endtask

   task set_site(logic [24:0] lat, logic [24:0] lon, logic [24:0] zone);
      write_reg(sst_pkg::CSR_LATITUDE, lat);
      write_reg(sst_pkg::CSR_LONGITUDE, lon);
      write_reg(sst_pkg::CSR_ZONE, zone);
      if ($urandom_range(1) == 1) write_reg(CSR_SPARE, 25'($urandom));
   endtask

   task send_query(bit [4:0] day, bit [3:0] month, bit rise, bit quiet);
      int gap;
      gap = (quiet || $urandom_range(3) != 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_day_of_month <= day;
      req_month_number <= month;
      req_want_sunrise <= rise;
      do @(posedge clock); while (busy);
      board.note_query(day, month, rise);
   endtask

   task drain;
      start <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   task random_batch(int n, bit quiet);
      bit [3:0] month;
      for (int i = 0; i < n; i++) begin
         month = ($urandom_range(7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
         send_query(5'($urandom), month, 1'($urandom), quiet);
      end
   endtask

   function logic [24:0] pick_lat();
      case ($urandom_range(3))
         0: return 25'($urandom);
         1: return $urandom_range(0, 1) ? 25'(24'sd5898240) : 25'(-24'sd5898240);
         default: return 25'(int'($urandom_range(0, 11796480)) - 5898240);
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: registers at reset, calendar extremes and wrapped day and month
      send_query(5'd1, 4'd1, 1'b1, 1'b1);
      send_query(5'd31, 4'd12, 1'b0, 1'b1);
      send_query(5'd0, 4'd0, 1'b1, 1'b1);
      send_query(5'd31, 4'd15, 1'b0, 1'b0);
      send_query(5'd15, 4'd6, 1'b1, 1'b0);
      drain;
      // polar summer and winter, saturated latitude, longitude and zone extremes
      set_site(25'(24'sd5898240), 25'(25'sd11796480), 25'(17'sd50400));
      send_query(5'd21, 4'd6, 1'b1, 1'b1);
      send_query(5'd21, 4'd12, 1'b0, 1'b1);
      send_query(5'd20, 4'd3, 1'b1, 1'b0);
      drain;
      set_site(25'h7FFFFF, 25'h0FFFFFF, 25'h0FFFF);
      send_query(5'd21, 4'd6, 1'b0, 1'b1);
      send_query(5'd1, 4'd1, 1'b1, 1'b1);
      drain;
      set_site(25'h800000, 25'h1000000, 25'h10000);
      send_query(5'd21, 4'd6, 1'b1, 1'b1);
      send_query(5'd21, 4'd12, 1'b0, 1'b1);
      drain;
      set_site(25'(-24'sd5898240), 25'(-25'sd11796480), 25'(-17'sd50400));
      send_query(5'd10, 4'd9, 1'b1, 1'b0);
      send_query(5'd10, 4'd9, 1'b0, 1'b0);
      drain;
      // near the polar circle, where no_event flips within days
      set_site(25'(24'sd4390000), 25'(25'sd1000000), 25'(17'sd3600));
      for (int d = 1; d <= 5; d++) send_query(5'(d * 6), 4'd12, 1'($urandom), 1'b0);
      drain;
      write_reg(CSR_SPARE, 25'h1FFFFFF);

      for (int p = 0; p < 8; p++) begin
         set_site(pick_lat(),
                  ($urandom_range(3) == 0) ? 25'($urandom)
                     : 25'(int'($urandom_range(0, 23592960)) - 11796480),
                  ($urandom_range(3) == 0) ? 25'($urandom)
                     : 25'(int'($urandom_range(0, 100800)) - 50400));
         random_batch(48, p == 7);
         drain;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
